// ===== sv/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// mss_pkg: shared types for the minimum-swap sorter
// Word formats of the input and result channels and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned SWAP_W  = 6;
	localparam logic [SWAP_W-1:0] SWAP_MAX = '1;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} item_t;

	typedef struct packed {
		logic [SWAP_W-1:0] swap_count;
		logic              overflow;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/mss_cmp.sv =====
// ----------------------------------------------------------------------------
// mss_cmp: ordering comparator
// Decides whether a stored element sorts ahead of the element being ranked,
// by signed value first and arrival index second.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_cmp #(
	parameter int unsigned IDX_W = 6
) (
	input  wire logic signed [mss_pkg::VALUE_W-1:0] other_value,
	input  wire logic        [IDX_W-1:0]            other_idx,
	input  wire logic signed [mss_pkg::VALUE_W-1:0] ref_value,
	input  wire logic        [IDX_W-1:0]            ref_idx,
	output logic                                    ahead
);
	import mss_pkg::*;

	logic less;
	logic equal;

	assign less   = other_value < ref_value;
	assign equal  = other_value == ref_value;
	// Equal values keep arrival order; the element itself never counts.
	assign ahead  = less || (equal && (other_idx < ref_idx));

endmodule

`default_nettype wire

// ===== sv/min_swaps_to_sort_by_cycles_core.sv =====
// ----------------------------------------------------------------------------
// min_swaps_to_sort_by_cycles_core: minimum swaps to sort a list
// Loads a list of signed values, ranks every element with one shared
// comparator, then walks the permutation cycles and reports the swap count.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 word
//  item      in         item_valid / item_stall   mss_pkg::item_t
//  result    out        result_valid / result_stall  mss_pkg::result_t
//
// Loading takes one word per cycle. After the last word the block stalls for
// ranking (one compare per cycle over the value store) and for cycle walking
// (a check per element and a walk step per swap), and then posts the result.
// Reset clears control state only; the stores need no clearing pass.
// A result waiting behind result_stall does not block loading of the next list.
// ----------------------------------------------------------------------------
`default_nettype none

module min_swaps_to_sort_by_cycles_core #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire mss_pkg::item_t    item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output mss_pkg::result_t       result
);
	import mss_pkg::*;

	localparam int unsigned IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int unsigned DW    = CNT_W + SWAP_W;

	typedef enum logic [3:0] {
		S_IDLE, S_RD_I, S_CAP_I, S_SWEEP, S_RWR, S_CRD, S_CHK, S_WALK, S_DONE
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [CNT_W-1:0] n_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] cj_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] rank_q;
	logic [CNT_W-1:0] cyc_q;
	logic signed [VALUE_W-1:0] vi_q;

	// Memories
	logic signed [VALUE_W-1:0] val_mem [MAX_ITEMS];
	logic        [IDX_W-1:0]   tgt_mem [MAX_ITEMS];
	logic                      vis_mem [MAX_ITEMS];
	logic signed [VALUE_W-1:0] val_rd_q;
	logic        [IDX_W-1:0]   tgt_rd_q;
	logic                      vis_rd_q;

	logic             item_acc;
	logic             full;
	logic [CNT_W-1:0] n_last;
	logic [IDX_W:0]   cj_inc;
	logic [IDX_W-1:0] val_addr;
	logic [IDX_W-1:0] tgt_raddr;
	logic             tgt_we;
	logic             vis_we;
	logic [IDX_W-1:0] vis_waddr;
	logic             vis_wdata;
	logic             ahead;
	logic [CNT_W-1:0] diff;
	logic [DW-1:0]    diff_w;
	logic [SWAP_W-1:0] swaps_sat;
	logic             i_is_last;
	logic             post_res;

	assign item_stall = state_q != S_IDLE;
	assign item_acc   = item_valid && !item_stall;
	assign full       = count_q == CNT_W'(MAX_ITEMS);
	assign n_last     = n_q - CNT_W'(1);
	assign cj_inc     = {1'b0, cj_q} + (IDX_W+1)'(1);
	assign i_is_last  = CNT_W'(i_q) == n_last;
	assign post_res   = (state_q == S_DONE) && (!result_valid || !result_stall);

	mss_cmp #(.IDX_W(IDX_W)) u_cmp (
		.other_value (val_rd_q),
		.other_idx   (cj_q),
		.ref_value   (vi_q),
		.ref_idx     (i_q),
		.ahead       (ahead)
	);

	always_comb begin
		unique case (state_q)
			S_RD_I:  val_addr = i_q;
			S_SWEEP: val_addr = cj_inc[IDX_W-1:0];
			default: val_addr = '0;
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_CHK, S_WALK: tgt_raddr = tgt_rd_q;
			default:       tgt_raddr = i_q;
		endcase
	end

	assign tgt_we = state_q == S_RWR;

	always_comb begin
		vis_we    = 1'b0;
		vis_waddr = i_q;
		vis_wdata = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				vis_we    = item_acc && !full;
				vis_waddr = count_q[IDX_W-1:0];
				vis_wdata = 1'b0;
			end
			S_CHK: begin
				vis_we = !vis_rd_q;
			end
			S_WALK: begin
				vis_we    = 1'b1;
				vis_waddr = k_q;
			end
			default: begin
				vis_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (item_acc && !full) begin
			val_mem[count_q[IDX_W-1:0]] <= item.value;
		end
		val_rd_q <= val_mem[val_addr];
	end

	always_ff @(posedge clk) begin
		if (tgt_we) begin
			tgt_mem[rank_q] <= i_q;
		end
		tgt_rd_q <= tgt_mem[tgt_raddr];
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_waddr] <= vis_wdata;
		end
		vis_rd_q <= vis_mem[i_q];
	end

	// The permutation cycles are disjoint and cover every element, so swaps = n - cyc_q.
	assign diff      = n_q - cyc_q;
	assign diff_w    = DW'(diff);
	assign swaps_sat = (diff_w > DW'(SWAP_MAX)) ? SWAP_MAX : diff_w[SWAP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			n_q          <= '0;
			i_q          <= '0;
			cj_q         <= '0;
			k_q          <= '0;
			rank_q       <= '0;
			cyc_q        <= '0;
			vi_q         <= '0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			if (post_res) begin
				result_valid <= 1'b1;
			end else if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						if (item.last) begin
							n_q     <= full ? count_q : count_q + CNT_W'(1);
							count_q <= '0;
							ovf_q   <= ovf_q | full;
							i_q     <= '0;
							state_q <= S_RD_I;
						end else if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				S_RD_I: begin
					state_q <= S_CAP_I;
				end
				S_CAP_I: begin
					vi_q    <= val_rd_q;
					cj_q    <= '0;
					rank_q  <= '0;
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					rank_q <= rank_q + IDX_W'(ahead);
					if (CNT_W'(cj_q) == n_last) begin
						state_q <= S_RWR;
					end else begin
						cj_q <= cj_inc[IDX_W-1:0];
					end
				end
				S_RWR: begin
					if (i_is_last) begin
						i_q     <= '0;
						cyc_q   <= '0;
						state_q <= S_CRD;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_RD_I;
					end
				end
				S_CRD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (!vis_rd_q) begin
						cyc_q <= cyc_q + CNT_W'(1);
					end
					if (!vis_rd_q && (tgt_rd_q != i_q)) begin
						k_q     <= tgt_rd_q;
						state_q <= S_WALK;
					end else if (i_is_last) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_CRD;
					end
				end
				S_WALK: begin
					if (tgt_rd_q != i_q) begin
						k_q <= tgt_rd_q;
					end else if (i_is_last) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_CRD;
					end
				end
				S_DONE: begin
					// Hold here while the previous result still waits.
					if (post_res) begin
						result.swap_count <= swaps_sat;
						result.overflow   <= ovf_q;
						ovf_q             <= 1'b0;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A list in progress always holds at least one element.
	a_n_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (n_q != '0))
		else $error("list length is zero while computing");

	// A rank always addresses an entry of the current list.
	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RWR) |-> (CNT_W'(rank_q) < n_q))
		else $error("rank beyond list length");

	// No more cycles than elements can be found.
	a_cyc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> (cyc_q <= n_q) && (cyc_q != '0))
		else $error("cycle count out of range");

	// A new result is posted only on leaving the final state.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> ($past(state_q) == S_DONE) && (state_q == S_IDLE))
		else $error("result posted outside the final state");

	// The load counter restarts after the last word of a list.
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && item.last) |=> (count_q == '0))
		else $error("item counter not cleared after last word");

endmodule

`default_nettype wire

// ===== dv/tb_min_swaps_to_sort_by_cycles_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_min_swaps_to_sort_by_cycles_core: self-checking bench for the swap sorter
// Sends lists of signed values, first from a short directed table and then
// as random lists of random length and spread, some of them longer than the
// store. A behavioral predictor ranks each untyped list and counts the swaps, and
// every result word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_min_swaps_to_sort_by_cycles_core;
	import mss_pkg::*;

	localparam int unsigned MAX_ITEMS = 64;
	localparam int unsigned RANDOM_ITEMS = 850;
	localparam int unsigned QUIET_ITEMS = 120;
	localparam int unsigned DRAIN_AT = 400;
	localparam int unsigned DIRECTED_N = 22;
	localparam longint unsigned CYCLE_LIMIT = 1_500_000;

	typedef logic signed [VALUE_W-1:0] elem_t;

	typedef struct packed {
		elem_t             value;
		logic              last;
		logic              is_typed;
		logic [SWAP_W-1:0] swaps;
		logic              ovf;
	} step_t;

	// Rows with is_typed set carry a result that is plain from the list itself.
	localparam step_t DIRECTED [DIRECTED_N] = '{
		'{32'sh8000_0000, 1'b1, 1'b1, 6'd0, 1'b0},
		'{32'sh7fff_ffff, 1'b1, 1'b1, 6'd0, 1'b0},
		'{32'sh7fff_ffff, 1'b0, 1'b0, 6'd0, 1'b0},
		'{32'sh8000_0000, 1'b1, 1'b1, 6'd1, 1'b0},
		'{32'sh8000_0000, 1'b0, 1'b0, 6'd0, 1'b0},
		'{32'sh7fff_ffff, 1'b1, 1'b1, 6'd0, 1'b0},
		'{32'sd5,         1'b0, 1'b0, 6'd0, 1'b0},
		'{32'sd5,         1'b0, 1'b0, 6'd0, 1'b0},
		'{32'sd5,         1'b1, 1'b1, 6'd0, 1'b0},
		'{32'sd3,         1'b0, 1'b0, 6'd0, 1'b0},
		'{32'sd2,         1'b0, 1'b0, 6'd0, 1'b0},
		'{32'sd1,         1'b1, 1'b0, 6'd0, 1'b0},
		'{32'sd0,         1'b0, 1'b0, 6'd0, 1'b0},
		'{-32'sd1,        1'b0, 1'b0, 6'd0, 1'b0},
		'{32'sd1,         1'b0, 1'b0, 6'd0, 1'b0},
		'{32'shffff_fffe, 1'b0, 1'b0, 6'd0, 1'b0},
		'{32'sh5555_5555, 1'b0, 1'b0, 6'd0, 1'b0},
		'{32'shaaaa_aaaa, 1'b1, 1'b0, 6'd0, 1'b0},
		'{32'sd4,         1'b0, 1'b0, 6'd0, 1'b0},
		'{32'sd1,         1'b0, 1'b0, 6'd0, 1'b0},
		'{32'sd2,         1'b0, 1'b0, 6'd0, 1'b0},
		'{32'sd3,         1'b1, 1'b0, 6'd0, 1'b0}
	};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item_word = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result_word;

	elem_t           list_vals[$];
	logic            list_ovf = 1'b0;
	result_t         expected_results[$];
	int unsigned     err_count = 0;
	int unsigned     items_sent = 0;
	int unsigned     stall_left = 0;
	bit              quiet = 1'b0;
	longint unsigned cycle_count = 0;

	min_swaps_to_sort_by_cycles_core #(
		.MAX_ITEMS(MAX_ITEMS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result_word)
	);

	always #5 clk = ~clk;

	// Stable rank of every stored element, then a walk from each unseen element not yet in place.
	function automatic result_t min_swap_count(input elem_t vals[$], input logic ovf);
		int unsigned by_rank[MAX_ITEMS];
		bit          seen[MAX_ITEMS];
		int unsigned n, rank, k, len, total;
		result_t     res;
		n = vals.size();
		total = 0;
		foreach (seen[i])
			seen[i] = 1'b0;
		for (int i = 0; i < n; i++) begin
			rank = 0;
			for (int j = 0; j < n; j++)
				if (vals[j] < vals[i] || (vals[j] == vals[i] && j < i))
					rank++;
			by_rank[rank] = i;
		end
		for (int i = 0; i < n; i++) begin
			if (!seen[i] && by_rank[i] != i) begin
				len = 0;
				k = i;
				while (!seen[k]) begin
					seen[k] = 1'b1;
					k = by_rank[k];
					len++;
				end
				total += len - 1;
			end
		end
		res.swap_count = (total > SWAP_MAX) ? SWAP_MAX : total[SWAP_W-1:0];
		res.overflow = ovf;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		err_count++;
	endtask

	// Starts and ends at a falling edge; the list tracking follows the block's store.
	task automatic send_word(input elem_t value, input logic last, input logic is_typed,
			input result_t typed_res);
		item_t w;
		w.value = value;
		w.last = last;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item_word <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (list_vals.size() < MAX_ITEMS)
			list_vals.push_back(value);
		else
			list_ovf = 1'b1;
		if (last) begin
			expected_results.push_back(is_typed ? typed_res : min_swap_count(list_vals, list_ovf));
			list_vals.delete();
			list_ovf = 1'b0;
		end
		items_sent++;
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			result_stall <= 1'b1;
			stall_left <= $urandom_range(0, 11);
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result word with no list outstanding");
			end else begin
				want = expected_results.pop_front();
				if (result_word.swap_count !== want.swap_count)
					report_mismatch($sformatf("swap_count %0d, wanted %0d",
						result_word.swap_count, want.swap_count));
				if (result_word.overflow !== want.overflow)
					report_mismatch($sformatf("overflow %0b, wanted %0b",
						result_word.overflow, want.overflow));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_min_swaps_to_sort_by_cycles_core: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned len, mode, stop_at;
		elem_t       v;
		bit          drained;
		drained = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_N; i++)
			send_word(DIRECTED[i].value, DIRECTED[i].last, DIRECTED[i].is_typed,
				result_t'{DIRECTED[i].swaps, DIRECTED[i].ovf});

		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			// Once, let the block run completely dry before the next list.
			if (!drained && items_sent >= DRAIN_AT) begin
				item_valid <= 1'b0;
				while (expected_results.size() != 0)
					@(negedge clk);
				@(negedge clk);
				drained = 1'b1;
			end
			if (items_sent + QUIET_ITEMS >= stop_at)
				quiet = 1'b1;
			mode = $urandom_range(0, 99);
			if (mode < 90)
				len = $urandom_range(1, 10);
			else if (mode < 96)
				len = $urandom_range(11, 30);
			else if (mode < 98)
				len = MAX_ITEMS;
			else
				len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
			mode = $urandom_range(0, 2);
			for (int i = 0; i < len; i++) begin
				case (mode)
				0: begin
					v = $urandom;
				end
				1: begin
					// Narrow spread, so that equal values are common.
					v = $urandom_range(0, 7) - 4;
				end
				default: begin
					case ($urandom_range(0, 4))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7fff_ffff;
					2: v = 32'sd0;
					3: v = -32'sd1;
					default: v = $urandom;
					endcase
				end
				endcase
				send_word(v, i == len - 1, 1'b0, '0);
			end
		end

		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (err_count == 0)
			$display("tb_min_swaps_to_sort_by_cycles_core: done, clean");
		else
			$display("tb_min_swaps_to_sort_by_cycles_core: done, errors");
		$finish;
	end

endmodule

// ===== min_swaps_to_sort_by_cycles_core.f =====
sv/mss_pkg.sv
sv/mss_cmp.sv
sv/min_swaps_to_sort_by_cycles_core.sv
dv/tb_min_swaps_to_sort_by_cycles_core.sv
